@@ rtl/dpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Doppler pitch ratio package
// Word types, outcome codes, internal widths and the sideband structs that
// travel next to the arithmetic cells of the pipeline.
// ----------------------------------------------------------------------------
package dpr_pkg;

  // Widths of the input and result fields.
  localparam int VEC_W  = 32;
  localparam int DIST_W = 31;
  localparam int FACT_W = 8;
  localparam int C_W    = 31;
  localparam int PITCH_W = 32;

  // Internal widths.
  localparam int PROD_W     = 2 * VEC_W;           // one signed product
  localparam int SUM_W      = PROD_W + 2;          // sum of three products
  localparam int MAG_W      = PROD_W;              // magnitude of that sum
  localparam int ROOT_W     = MAG_W / 2;           // integer square root
  localparam int SQRT_STEPS = MAG_W / 2;           // one root bit per cell
  localparam int SNUM_W     = MAG_W + FACT_W;      // speed dividend
  localparam int SDEN_W     = DIST_W + 5;          // distance times 32
  localparam int SQ_W       = SNUM_W - 5;          // speed quotient bits
  localparam int RDEN_W     = SQ_W + 1;            // ratio divisor
  localparam int RQ_W       = PITCH_W + 1;         // ratio quotient bits

  // Input word.
  typedef struct packed {
    logic signed [VEC_W-1:0] rel_pos_x;
    logic signed [VEC_W-1:0] rel_pos_y;
    logic signed [VEC_W-1:0] rel_pos_z;
    logic [DIST_W-1:0]       distance;
    logic signed [VEC_W-1:0] src_vel_x;
    logic signed [VEC_W-1:0] src_vel_y;
    logic signed [VEC_W-1:0] src_vel_z;
    logic signed [VEC_W-1:0] lis_vel_x;
    logic signed [VEC_W-1:0] lis_vel_y;
    logic signed [VEC_W-1:0] lis_vel_z;
    logic [FACT_W-1:0]       doppler_factor;
  } dpr_in_t;

  // Outcome codes of a result word.
  typedef enum logic [1:0] {
    OUT_DISABLED = 2'd0,
    OUT_LIS_FAST = 2'd1,
    OUT_SRC_FAST = 2'd2,
    OUT_RATIO    = 2'd3
  } outcome_t;

  // Result word.
  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    outcome_t           outcome;
  } dpr_out_t;

  // Sideband along the square root cells.
  typedef struct packed {
    logic              mode;     // high: distance mode
    logic [DIST_W-1:0] dlen;
    logic [FACT_W-1:0] fact;
    logic [MAG_W-1:0]  mag_s;
    logic              neg_s;
    logic [MAG_W-1:0]  mag_l;
    logic              neg_l;
  } sq_side_t;

  // Sideband along the speed division cells.
  typedef struct packed {
    logic [SDEN_W-1:0] den;
    logic              sgn_s;    // source speed is negative if nonzero
    logic              sgn_l;    // listener speed is negative if nonzero
  } sp_side_t;

  // Sideband along the ratio division cells.
  typedef struct packed {
    logic [RDEN_W-1:0] den;
    outcome_t          outcome;
    logic              ovf;      // quotient too large for the cell row
  } rt_side_t;

endpackage

@@ rtl/dpr_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One step of a digit-by-digit integer square root: tries one root bit and
// registers the reduced radicand and the partial root.
// ----------------------------------------------------------------------------
module dpr_sqrt_cell #(
  parameter int BIT_POS = 62
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [dpr_pkg::MAG_W-1:0]  x_in,
  input  logic [dpr_pkg::MAG_W-1:0]  root_in,
  output logic [dpr_pkg::MAG_W-1:0]  x_out,
  output logic [dpr_pkg::MAG_W-1:0]  root_out
);

  localparam logic [dpr_pkg::MAG_W-1:0] BIT = dpr_pkg::MAG_W'(1) << BIT_POS;

  logic [dpr_pkg::MAG_W-1:0] x_r, x_nxt;
  logic [dpr_pkg::MAG_W-1:0] root_r, root_nxt;
  logic [dpr_pkg::MAG_W-1:0] trial;

  // Try the current bit against the remaining radicand.
  always_comb begin
    trial = root_in + BIT;
    if (x_in >= trial) begin
      x_nxt    = x_in - trial;
      root_nxt = (root_in >> 1) + BIT;
    end else begin
      x_nxt    = x_in;
      root_nxt = root_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      root_r <= root_nxt;
    end
  end

  assign x_out    = x_r;
  assign root_out = root_r;

endmodule

@@ rtl/dpr_div_cell.sv @@
// ----------------------------------------------------------------------------
// Division cell
// One restoring division step: shifts the next dividend bit into the
// remainder, subtracts the divisor if it fits and shifts in a quotient bit.
// ----------------------------------------------------------------------------
module dpr_div_cell #(
  parameter int DEN_W = 36,
  parameter int QUO_W = 67
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [QUO_W-1:0] nq_in,    // dividend bits on top, quotient below
  input  logic [DEN_W-1:0] den,
  output logic [DEN_W-1:0] rem_out,
  output logic [QUO_W-1:0] nq_out
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] nq_r, nq_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  // Trial subtraction; a remainder that enters below the divisor stays below it.
  always_comb begin
    shifted = {rem_in, nq_in[QUO_W-1]};
    diff    = shifted - {1'b0, den};
    if (!diff[DEN_W]) begin
      rem_nxt = diff[DEN_W-1:0];
      nq_nxt  = {nq_in[QUO_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DEN_W-1:0];
      nq_nxt  = {nq_in[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign rem_out = rem_r;
  assign nq_out  = nq_r;

endmodule

@@ rtl/doppler_pitch_ratio.sv @@
// ----------------------------------------------------------------------------
// Doppler pitch ratio
// Pipelined pitch ratio (c - l) / (c - s) from position and velocities.
// ----------------------------------------------------------------------------
// Usage:
//   Write the speed of sound on the cfg channel (cfg_valid/cfg_ready, always
//   ready) while no word is in flight; zero turns the Doppler effect off.
//   Each input word (in_valid, in_stall) gives one result word (out_valid,
//   out_stall) with the pitch and an outcome code.
//   The path from acceptance to out_valid runs through one product stage,
//   one sum stage, 32 square root cells, one scaling multiply, 67 cells of
//   the speed division, two setup stages, 33 cells of the ratio division
//   and the output register. Throughput is one word per clock while no
//   result is stalled; every stage advances together.
//   When the receiver stalls a valid result, the whole row holds and
//   in_stall is raised in the same cycle; words already inside are kept.
//   Reset (rst_n low, synchronous) empties the pipeline and clears the speed
//   of sound to zero.
// ----------------------------------------------------------------------------
module doppler_pitch_ratio #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dpr_pkg::dpr_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dpr_pkg::dpr_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dpr_pkg::C_W-1:0]      cfg_data
);

  localparam int NUMW_W = dpr_pkg::RDEN_W + FRAC_BITS;
  localparam logic [63:0] PMAX_FULL = 64'd65535 << FRAC_BITS;
  localparam logic [dpr_pkg::PITCH_W-1:0] PITCH_MAX =
    (PMAX_FULL > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : PMAX_FULL[31:0];
  localparam logic [dpr_pkg::PITCH_W-1:0] PITCH_ONE =
    dpr_pkg::PITCH_W'(1) << FRAC_BITS;
  localparam int SPD_STEPS = dpr_pkg::SQ_W;
  localparam int RT_STEPS  = dpr_pkg::RQ_W;

  // Speed of sound register.
  logic [dpr_pkg::C_W-1:0] c_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      c_r <= cfg_data;
    end
  end

  // Global advance: everything moves unless a result is held at the output.
  logic adv;
  logic out_valid_r;
  dpr_pkg::dpr_out_t out_data_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Product stage: dot product terms or squares, by mode.
  logic                                mode_a;
  logic signed [dpr_pkg::VEC_W-1:0]    as_x, as_y, as_z, al_x, al_y, al_z;
  logic signed [dpr_pkg::PROD_W-1:0]   ps_r [3];
  logic signed [dpr_pkg::PROD_W-1:0]   pl_r [3];
  logic                                a_v_r, a_mode_r;
  logic [dpr_pkg::DIST_W-1:0]          a_dist_r;
  logic [dpr_pkg::FACT_W-1:0]          a_fact_r;

  always_comb begin
    mode_a = (in_data.distance != '0);
    as_x = mode_a ? in_data.rel_pos_x : in_data.src_vel_x;
    as_y = mode_a ? in_data.rel_pos_y : in_data.src_vel_y;
    as_z = mode_a ? in_data.rel_pos_z : in_data.src_vel_z;
    al_x = mode_a ? in_data.rel_pos_x : in_data.lis_vel_x;
    al_y = mode_a ? in_data.rel_pos_y : in_data.lis_vel_y;
    al_z = mode_a ? in_data.rel_pos_z : in_data.lis_vel_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ps_r[0]  <= as_x * in_data.src_vel_x;
      ps_r[1]  <= as_y * in_data.src_vel_y;
      ps_r[2]  <= as_z * in_data.src_vel_z;
      pl_r[0]  <= al_x * in_data.lis_vel_x;
      pl_r[1]  <= al_y * in_data.lis_vel_y;
      pl_r[2]  <= al_z * in_data.lis_vel_z;
      a_mode_r <= mode_a;
      a_dist_r <= in_data.distance;
      a_fact_r <= in_data.doppler_factor;
    end
  end

  // Sum stage: signed sums split into sign and magnitude.
  logic signed [dpr_pkg::SUM_W-1:0] sum_s, sum_l, abs_s, abs_l;
  dpr_pkg::sq_side_t                b_side_nxt, b_side_r;
  logic                             b_v_r;

  always_comb begin
    sum_s = dpr_pkg::SUM_W'(ps_r[0]) + dpr_pkg::SUM_W'(ps_r[1])
          + dpr_pkg::SUM_W'(ps_r[2]);
    sum_l = dpr_pkg::SUM_W'(pl_r[0]) + dpr_pkg::SUM_W'(pl_r[1])
          + dpr_pkg::SUM_W'(pl_r[2]);
    abs_s = sum_s[dpr_pkg::SUM_W-1] ? -sum_s : sum_s;
    abs_l = sum_l[dpr_pkg::SUM_W-1] ? -sum_l : sum_l;
    b_side_nxt.mode  = a_mode_r;
    b_side_nxt.dlen  = a_dist_r;
    b_side_nxt.fact  = a_fact_r;
    b_side_nxt.mag_s = abs_s[dpr_pkg::MAG_W-1:0];
    b_side_nxt.neg_s = sum_s[dpr_pkg::SUM_W-1];
    b_side_nxt.mag_l = abs_l[dpr_pkg::MAG_W-1:0];
    b_side_nxt.neg_l = sum_l[dpr_pkg::SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side_r <= b_side_nxt;
    end
  end

  // Square root row: integer roots of both sums (squares in velocity mode).
  logic [dpr_pkg::MAG_W-1:0] sq_xs [dpr_pkg::SQRT_STEPS];
  logic [dpr_pkg::MAG_W-1:0] sq_rs [dpr_pkg::SQRT_STEPS];
  logic [dpr_pkg::MAG_W-1:0] sq_xl [dpr_pkg::SQRT_STEPS];
  logic [dpr_pkg::MAG_W-1:0] sq_rl [dpr_pkg::SQRT_STEPS];
  dpr_pkg::sq_side_t         sq_side_r [dpr_pkg::SQRT_STEPS];
  logic [dpr_pkg::SQRT_STEPS-1:0] sq_v_r;

  for (genvar k = 0; k < dpr_pkg::SQRT_STEPS; k++) begin : g_sqrt
    logic [dpr_pkg::MAG_W-1:0] xs_in, rs_in, xl_in, rl_in;

    if (k == 0) begin : g_first
      assign xs_in = b_side_r.mag_s;
      assign rs_in = '0;
      assign xl_in = b_side_r.mag_l;
      assign rl_in = '0;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[k] <= 1'b0;
        end else if (adv) begin
          sq_v_r[k] <= b_v_r;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_side_r[k] <= b_side_r;
        end
      end
    end else begin : g_next
      assign xs_in = sq_xs[k-1];
      assign rs_in = sq_rs[k-1];
      assign xl_in = sq_xl[k-1];
      assign rl_in = sq_rl[k-1];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[k] <= 1'b0;
        end else if (adv) begin
          sq_v_r[k] <= sq_v_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_side_r[k] <= sq_side_r[k-1];
        end
      end
    end

    dpr_sqrt_cell #(.BIT_POS(dpr_pkg::MAG_W - 2 - 2 * k)) u_sqrt_s (
      .clk(clk), .en(adv), .x_in(xs_in), .root_in(rs_in),
      .x_out(sq_xs[k]), .root_out(sq_rs[k])
    );
    dpr_sqrt_cell #(.BIT_POS(dpr_pkg::MAG_W - 2 - 2 * k)) u_sqrt_l (
      .clk(clk), .en(adv), .x_in(xl_in), .root_in(rl_in),
      .x_out(sq_xl[k]), .root_out(sq_rl[k])
    );
  end

  // Scaling stage: dividend times the Doppler factor, divisor by mode.
  dpr_pkg::sq_side_t            d_src;
  logic [dpr_pkg::MAG_W-1:0]    d_base_s, d_base_l;
  logic [dpr_pkg::SNUM_W-1:0]   d_num_s_r, d_num_l_r;
  dpr_pkg::sp_side_t            d_side_nxt, d_side_r;
  logic                         d_v_r;

  always_comb begin
    d_src    = sq_side_r[dpr_pkg::SQRT_STEPS-1];
    d_base_s = d_src.mode ? d_src.mag_s
             : dpr_pkg::MAG_W'(sq_rs[dpr_pkg::SQRT_STEPS-1][dpr_pkg::ROOT_W-1:0]);
    d_base_l = d_src.mode ? d_src.mag_l
             : dpr_pkg::MAG_W'(sq_rl[dpr_pkg::SQRT_STEPS-1][dpr_pkg::ROOT_W-1:0]);
    d_side_nxt.den   = d_src.mode ? {d_src.dlen, 5'b0} : dpr_pkg::SDEN_W'(32);
    d_side_nxt.sgn_s = d_src.mode ? !d_src.neg_s : 1'b1;
    d_side_nxt.sgn_l = d_src.mode ? !d_src.neg_l : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= sq_v_r[dpr_pkg::SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_num_s_r <= dpr_pkg::SNUM_W'(d_base_s) * dpr_pkg::SNUM_W'(d_src.fact);
      d_num_l_r <= dpr_pkg::SNUM_W'(d_base_l) * dpr_pkg::SNUM_W'(d_src.fact);
      d_side_r  <= d_side_nxt;
    end
  end

  // Speed division row: source and listener speeds side by side.
  logic [dpr_pkg::SDEN_W-1:0] sp_rem_s [SPD_STEPS];
  logic [dpr_pkg::SQ_W-1:0]   sp_nq_s  [SPD_STEPS];
  logic [dpr_pkg::SDEN_W-1:0] sp_rem_l [SPD_STEPS];
  logic [dpr_pkg::SQ_W-1:0]   sp_nq_l  [SPD_STEPS];
  dpr_pkg::sp_side_t          sp_side_r [SPD_STEPS];
  logic [SPD_STEPS-1:0]       sp_v_r;

  for (genvar k = 0; k < SPD_STEPS; k++) begin : g_spd
    logic [dpr_pkg::SDEN_W-1:0] rs_in, rl_in;
    logic [dpr_pkg::SQ_W-1:0]   qs_in, ql_in;
    dpr_pkg::sp_side_t          side_in;

    if (k == 0) begin : g_first
      assign rs_in   = dpr_pkg::SDEN_W'(d_num_s_r[dpr_pkg::SNUM_W-1:dpr_pkg::SQ_W]);
      assign qs_in   = d_num_s_r[dpr_pkg::SQ_W-1:0];
      assign rl_in   = dpr_pkg::SDEN_W'(d_num_l_r[dpr_pkg::SNUM_W-1:dpr_pkg::SQ_W]);
      assign ql_in   = d_num_l_r[dpr_pkg::SQ_W-1:0];
      assign side_in = d_side_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sp_v_r[k] <= 1'b0;
        end else if (adv) begin
          sp_v_r[k] <= d_v_r;
        end
      end
    end else begin : g_next
      assign rs_in   = sp_rem_s[k-1];
      assign qs_in   = sp_nq_s[k-1];
      assign rl_in   = sp_rem_l[k-1];
      assign ql_in   = sp_nq_l[k-1];
      assign side_in = sp_side_r[k-1];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sp_v_r[k] <= 1'b0;
        end else if (adv) begin
          sp_v_r[k] <= sp_v_r[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sp_side_r[k] <= side_in;
      end
    end

    dpr_div_cell #(.DEN_W(dpr_pkg::SDEN_W), .QUO_W(dpr_pkg::SQ_W)) u_div_s (
      .clk(clk), .en(adv), .rem_in(rs_in), .nq_in(qs_in), .den(side_in.den),
      .rem_out(sp_rem_s[k]), .nq_out(sp_nq_s[k])
    );
    dpr_div_cell #(.DEN_W(dpr_pkg::SDEN_W), .QUO_W(dpr_pkg::SQ_W)) u_div_l (
      .clk(clk), .en(adv), .rem_in(rl_in), .nq_in(ql_in), .den(side_in.den),
      .rem_out(sp_rem_l[k]), .nq_out(sp_nq_l[k])
    );
  end

  // Classification stage: special outcomes, ratio numerator and divisor.
  logic [dpr_pkg::SQ_W-1:0]   e_qs, e_ql, e_c;
  logic                       e_neg_s, e_neg_l, e_lfast, e_sfast;
  dpr_pkg::sp_side_t          e_src;
  dpr_pkg::outcome_t          e_outcome;
  logic [dpr_pkg::RDEN_W-1:0] e_c_w;
  logic [dpr_pkg::RDEN_W-1:0] e1_num_r, e1_den_r;
  dpr_pkg::outcome_t          e1_outcome_r;
  logic                       e1_v_r;

  always_comb begin
    e_src   = sp_side_r[SPD_STEPS-1];
    e_qs    = sp_nq_s[SPD_STEPS-1];
    e_ql    = sp_nq_l[SPD_STEPS-1];
    e_c     = dpr_pkg::SQ_W'(c_r);
    e_c_w   = dpr_pkg::RDEN_W'(c_r);
    e_neg_s = e_src.sgn_s && (e_qs != '0);
    e_neg_l = e_src.sgn_l && (e_ql != '0);
    e_lfast = !e_neg_l && (e_ql > e_c);
    e_sfast = !e_neg_s && (e_qs >= e_c);
    if (c_r == '0) begin
      e_outcome = dpr_pkg::OUT_DISABLED;
    end else if (e_lfast) begin
      e_outcome = dpr_pkg::OUT_LIS_FAST;
    end else if (e_sfast) begin
      e_outcome = dpr_pkg::OUT_SRC_FAST;
    end else begin
      e_outcome = dpr_pkg::OUT_RATIO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else if (adv) begin
      e1_v_r <= sp_v_r[SPD_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_num_r     <= e_neg_l ? e_c_w + dpr_pkg::RDEN_W'(e_ql)
                              : e_c_w - dpr_pkg::RDEN_W'(e_ql);
      e1_den_r     <= e_neg_s ? e_c_w + dpr_pkg::RDEN_W'(e_qs)
                              : e_c_w - dpr_pkg::RDEN_W'(e_qs);
      e1_outcome_r <= e_outcome;
    end
  end

  // Ratio setup stage: scale the numerator and catch quotient overflow.
  logic [NUMW_W-1:0]          f_numw, f_high;
  dpr_pkg::rt_side_t          f_side_nxt, f_side_r;
  logic [dpr_pkg::RDEN_W-1:0] f_rem_r;
  logic [dpr_pkg::RQ_W-1:0]   f_nq_r;
  logic                       f_v_r;

  always_comb begin
    f_numw             = NUMW_W'(e1_num_r) << FRAC_BITS;
    f_high             = f_numw >> dpr_pkg::RQ_W;
    f_side_nxt.den     = e1_den_r;
    f_side_nxt.outcome = e1_outcome_r;
    f_side_nxt.ovf     = (f_high >= NUMW_W'(e1_den_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side_r <= f_side_nxt;
      f_rem_r  <= f_side_nxt.ovf ? '0 : f_high[dpr_pkg::RDEN_W-1:0];
      f_nq_r   <= f_numw[dpr_pkg::RQ_W-1:0];
    end
  end

  // Ratio division row.
  logic [dpr_pkg::RDEN_W-1:0] rt_rem [RT_STEPS];
  logic [dpr_pkg::RQ_W-1:0]   rt_nq  [RT_STEPS];
  dpr_pkg::rt_side_t          rt_side_r [RT_STEPS];
  logic [RT_STEPS-1:0]        rt_v_r;

  for (genvar k = 0; k < RT_STEPS; k++) begin : g_rt
    logic [dpr_pkg::RDEN_W-1:0] r_in;
    logic [dpr_pkg::RQ_W-1:0]   q_in;
    dpr_pkg::rt_side_t          side_in;

    if (k == 0) begin : g_first
      assign r_in    = f_rem_r;
      assign q_in    = f_nq_r;
      assign side_in = f_side_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rt_v_r[k] <= 1'b0;
        end else if (adv) begin
          rt_v_r[k] <= f_v_r;
        end
      end
    end else begin : g_next
      assign r_in    = rt_rem[k-1];
      assign q_in    = rt_nq[k-1];
      assign side_in = rt_side_r[k-1];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rt_v_r[k] <= 1'b0;
        end else if (adv) begin
          rt_v_r[k] <= rt_v_r[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_side_r[k] <= side_in;
      end
    end

    dpr_div_cell #(.DEN_W(dpr_pkg::RDEN_W), .QUO_W(dpr_pkg::RQ_W)) u_div_r (
      .clk(clk), .en(adv), .rem_in(r_in), .nq_in(q_in), .den(side_in.den),
      .rem_out(rt_rem[k]), .nq_out(rt_nq[k])
    );
  end

  // Output register: pitch by outcome, ratio saturated.
  dpr_pkg::rt_side_t        o_src;
  logic [dpr_pkg::RQ_W-1:0] o_q;
  dpr_pkg::dpr_out_t        o_nxt;

  always_comb begin
    o_src         = rt_side_r[RT_STEPS-1];
    o_q           = rt_nq[RT_STEPS-1];
    o_nxt.outcome = o_src.outcome;
    case (o_src.outcome)
      dpr_pkg::OUT_DISABLED: o_nxt.pitch = PITCH_ONE;
      dpr_pkg::OUT_LIS_FAST: o_nxt.pitch = '0;
      dpr_pkg::OUT_SRC_FAST: o_nxt.pitch = PITCH_MAX;
      default: begin
        if (o_src.ovf || (o_q > dpr_pkg::RQ_W'(PITCH_MAX))) begin
          o_nxt.pitch = PITCH_MAX;
        end else begin
          o_nxt.pitch = o_q[dpr_pkg::PITCH_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rt_v_r[RT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= o_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the result word and the stall path.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.outcome == dpr_pkg::OUT_RATIO)
      |-> (out_data_r.pitch <= PITCH_MAX))
    else $error("ratio pitch above saturation value");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.outcome == dpr_pkg::OUT_LIS_FAST)
      |-> (out_data_r.pitch == '0))
    else $error("listener too fast but pitch nonzero");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (c_r == '0)) |-> (out_data_r.outcome == dpr_pkg::OUT_DISABLED))
    else $error("zero speed of sound without disabled outcome");

endmodule
